/* rtl/core/radio_packet_deframer_macros.svh */
// Assertion macros shared by the radio packet deframer RTL.
`ifndef RADIO_PACKET_DEFRAMER_MACROS_SVH
`define RADIO_PACKET_DEFRAMER_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on clk and disabled during rst.
`define RPD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("radio_packet_deframer: assertion failed");
// Next-cycle implication, checked on clk and disabled during rst.
`define RPD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("radio_packet_deframer: assertion failed");
`else
`define RPD_ASSERT_IMP(label, ante, cons)
`define RPD_ASSERT_NEXT(label, ante, cons)
`endif

`endif

/* rtl/core/rpd_pkg.sv */
// Types, codes and CRC function shared by the radio packet deframer.
`default_nettype none

package rpd_pkg;

  typedef struct packed {
    logic       cmd;
    logic [7:0] rx_byte;
  } rpd_item_t;

  typedef struct packed {
    logic       is_status;
    logic [7:0] data_byte;
    logic [2:0] status;
    logic       peer_acked;
    logic       ack_needed;
    logic       last;
  } rpd_result_t;

  typedef enum logic [2:0] {
    STS_NEW   = 3'd0,
    STS_DUP   = 3'd1,
    STS_EMPTY = 3'd2,
    STS_CRC   = 3'd3,
    STS_OVF   = 3'd4
  } rpd_code_t;

  typedef enum logic [1:0] {
    EV_NONE,
    EV_STATUS,
    EV_DATA
  } rpd_event_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EMIT,
    ST_STATUS
  } rpd_state_t;

  typedef struct packed {
    logic take;
    logic rd;
    logic emit_data;
    logic emit_status;
  } rpd_cmd_t;

  typedef struct packed {
    rpd_event_t ev;
    logic       rd_last;
    logic       out_free;
  } rpd_flag_t;

  localparam logic [7:0] CRC_POLY  = 8'h8C;
  localparam logic [7:0] BYTE_ZERO = 8'h00;
  localparam logic [7:0] BYTE_ONES = 8'hFF;
  localparam logic [7:0] ID_RESET  = 8'hFF;

  // CRC-8, reflected polynomial 0x8C, one byte per call.
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/rpd_ctrl.sv */
// Controller state machine: accept, payload drain and status emission.
`default_nettype none

module rpd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  rpd_pkg::rpd_flag_t flag,
  output rpd_pkg::rpd_cmd_t  ctl
);
  import rpd_pkg::*;

  rpd_state_t state;
  rpd_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    item_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        item_stall = 1'b0;
        ctl.take   = item_valid;
        if (item_valid) begin
          case (flag.ev)
            EV_STATUS: state_next = ST_STATUS;
            EV_DATA:   state_next = ST_READ;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_READ: begin
        ctl.rd     = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        // hold the read byte until the output register frees up
        if (flag.out_free) begin
          ctl.emit_data = 1'b1;
          state_next    = flag.rd_last ? ST_STATUS : ST_READ;
        end
      end
      ST_STATUS: begin
        if (flag.out_free) begin
          ctl.emit_status = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/rpd_dpath.sv */
// Datapath: unstuffing, frame store, CRC check, frame decode and output register.
`default_nettype none

module rpd_dpath #(
  parameter int FRAME_DEPTH = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  rpd_pkg::rpd_item_t   item,
  input  rpd_pkg::rpd_cmd_t    ctl,
  output rpd_pkg::rpd_flag_t   flag,
  output logic                 result_valid,
  input  logic                 result_stall,
  output rpd_pkg::rpd_result_t result
);
  import rpd_pkg::*;

  localparam int CW = $clog2(FRAME_DEPTH + 1);
  localparam int AW = $clog2(FRAME_DEPTH);

  logic [7:0]    mem [FRAME_DEPTH];

  logic [CW-1:0] byte_count;
  logic          skip_next;
  logic [7:0]    running_crc;
  logic [7:0]    previous_id;

  logic          hdr_ack;
  logic [7:0]    len_reg;
  logic [7:0]    id_reg;
  rpd_code_t     sts_code;
  logic          sts_acked;
  logic          sts_ackneed;
  logic [7:0]    rd_idx;
  logic [7:0]    rd_data;

  logic [CW-1:0] cnt_inc;
  logic [8:0]    need;
  logic          at_full;
  logic          complete;
  logic          stuff_mark;
  logic          store_byte;
  logic [AW-1:0] rd_addr;
  rpd_event_t    ev;
  rpd_code_t     code_n;
  logic          acked_n;
  logic          ackneed_n;

  assign cnt_inc    = byte_count + CW'(1);
  assign need       = (len_reg == 8'd0) ? 9'd3 : ({1'b0, len_reg} + 9'd4);
  assign at_full    = (byte_count == CW'(FRAME_DEPTH));
  assign complete   = (byte_count >= CW'(2)) &&
                      ({{9{1'b0}}, cnt_inc} == {{CW{1'b0}}, need});
  assign stuff_mark = (item.rx_byte == BYTE_ZERO) || (item.rx_byte == BYTE_ONES);
  assign store_byte = !item.cmd && !at_full && !skip_next;
  assign rd_addr    = AW'({1'b0, rd_idx} + 9'd3);

  // decode what the current beat completes
  always_comb begin
    ev        = EV_NONE;
    code_n    = STS_NEW;
    acked_n   = 1'b0;
    ackneed_n = 1'b0;
    if (item.cmd) begin
      ev = EV_NONE;
    end else if (at_full) begin
      ev     = EV_STATUS;
      code_n = STS_OVF;
    end else if (!skip_next && complete) begin
      ev = EV_STATUS;
      if (item.rx_byte != running_crc) begin
        code_n = STS_CRC;
      end else if (len_reg == 8'd0) begin
        code_n  = STS_EMPTY;
        acked_n = hdr_ack;
      end else if (id_reg == previous_id) begin
        code_n    = STS_DUP;
        acked_n   = hdr_ack;
        ackneed_n = 1'b1;
      end else begin
        ev        = EV_DATA;
        code_n    = STS_NEW;
        acked_n   = hdr_ack;
        ackneed_n = 1'b1;
      end
    end
  end

  assign flag.ev       = ev;
  assign flag.rd_last  = (rd_idx == (len_reg - 8'd1));
  assign flag.out_free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count  <= '0;
      skip_next   <= 1'b0;
      running_crc <= 8'h00;
      previous_id <= ID_RESET;
    end else if (ctl.take) begin
      if (item.cmd || at_full) begin
        byte_count  <= '0;
        skip_next   <= 1'b0;
        running_crc <= 8'h00;
      end else if (skip_next) begin
        skip_next <= 1'b0;
      end else if (complete) begin
        byte_count  <= '0;
        skip_next   <= 1'b0;
        running_crc <= 8'h00;
        if (ev == EV_DATA) begin
          previous_id <= id_reg;
        end
      end else begin
        byte_count  <= cnt_inc;
        skip_next   <= stuff_mark;
        running_crc <= crc8_update(running_crc, item.rx_byte);
      end
    end
  end

  // frame store and header capture
  always_ff @(posedge clk) begin
    if (ctl.take && store_byte) begin
      mem[byte_count[AW-1:0]] <= item.rx_byte;
      if (byte_count == CW'(0)) begin
        hdr_ack <= item.rx_byte[0];
      end
      if (byte_count == CW'(1)) begin
        len_reg <= item.rx_byte;
      end
      if (byte_count == CW'(2)) begin
        id_reg <= item.rx_byte;
      end
    end
    if (ctl.rd) begin
      rd_data <= mem[rd_addr];
    end
  end

  // pending status and drain index
  always_ff @(posedge clk) begin
    if (ctl.take) begin
      sts_code    <= code_n;
      sts_acked   <= acked_n;
      sts_ackneed <= ackneed_n;
      rd_idx      <= 8'd0;
    end else if (ctl.emit_data) begin
      rd_idx <= rd_idx + 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ctl.emit_data || ctl.emit_status) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit_data) begin
      result.is_status  <= 1'b0;
      result.data_byte  <= rd_data;
      result.status     <= STS_NEW;
      result.peer_acked <= 1'b0;
      result.ack_needed <= 1'b0;
      result.last       <= 1'b0;
    end else if (ctl.emit_status) begin
      result.is_status  <= 1'b1;
      result.data_byte  <= 8'h00;
      result.status     <= sts_code;
      result.peer_acked <= sts_acked;
      result.ack_needed <= sts_ackneed;
      result.last       <= 1'b1;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/radio_packet_deframer.sv */
// Radio packet deframer top level: byte unstuffing, CRC-8 check, payload delivery.
// A beat that completes no frame is taken without holding the input. A beat that ends a
// frame holds the input until the status state has loaded its status result into the
// output register; each data byte of a good new frame first passes from the single-port
// frame store through the read and emit states. Output stalls extend the hold. Synchronous
// reset clears the frame state and sets the last id to 0xFF; the frame store is not cleared.
`default_nettype none

`include "radio_packet_deframer_macros.svh"

module radio_packet_deframer #(
  parameter int FRAME_DEPTH = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  rpd_pkg::rpd_item_t   item,
  output logic                 result_valid,
  input  logic                 result_stall,
  output rpd_pkg::rpd_result_t result
);
  import rpd_pkg::*;

  rpd_cmd_t  ctl;
  rpd_flag_t flag;

  rpd_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .flag       (flag),
    .ctl        (ctl)
  );

  rpd_dpath #(
    .FRAME_DEPTH (FRAME_DEPTH)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .ctl          (ctl),
    .flag         (flag),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  `RPD_ASSERT_IMP(a_one_action, 1'b1,
                  $onehot0({ctl.take, ctl.rd, ctl.emit_data, ctl.emit_status}))
  `RPD_ASSERT_NEXT(a_status_shown, ctl.emit_status,
                   result_valid && result.last && result.is_status)
  `RPD_ASSERT_IMP(a_data_clean, result_valid && !result.is_status,
                  !result.last && (result.status == STS_NEW) && !result.ack_needed)

endmodule

`default_nettype wire
